/* rtl/core/ones_complement_partial_checksum_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the checksum RTL. Defining ASSERT_OFF
// removes every check.
// ---------------------------------------------------------------------------
`ifndef ONES_COMPLEMENT_PARTIAL_CHECKSUM_MACROS_SVH
`define ONES_COMPLEMENT_PARTIAL_CHECKSUM_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define OCPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be seen outside reset
`define OCPC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OCPC_ASSERT(label, clk, rst_n, prop, msg)
`define OCPC_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/ocpc_pkg.sv */
// ---------------------------------------------------------------------------
// Checksum package
// Transaction types and the ones-complement helper functions.
// ---------------------------------------------------------------------------
package ocpc_pkg;

    localparam int unsigned WordBytes = 8;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        first_item;
        logic        last_item;
        logic [63:0] initial_sum;
        logic        odd_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] checksum;
    } t_out_item;

    // next state and result of one item
    typedef struct packed {
        logic [63:0] acc;
        logic        odd;
        logic        emit;
        logic [63:0] checksum;
    } t_step;

    // zero the bytes at or above the valid count (9..15 count as 8)
    function automatic logic [63:0] keep_bytes(logic [63:0] w, logic [3:0] count);
        logic [63:0] r;
        r = w;
        for (int k = 0; k < WordBytes; k++) begin
            if (count <= 4'(k)) begin
                r[k*8 +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

    // 64-bit add with end-around carry
    function automatic logic [63:0] add_eac64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63:0] + {63'd0, s[64]};
    endfunction

    function automatic logic [31:0] fold_to32(logic [63:0] v);
        logic [32:0] t;
        logic [32:0] u;
        t = {1'b0, v[63:32]} + {1'b0, v[31:0]};
        u = {1'b0, t[31:0]} + {32'd0, t[32]};
        return u[31:0];
    endfunction

    function automatic logic [15:0] fold_to16(logic [31:0] v);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, v[31:16]} + {1'b0, v[15:0]};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        return u[15:0];
    endfunction

endpackage

/* rtl/core/ocpc_chan_if.sv */
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface ocpc_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ocpc_step.sv */
// ---------------------------------------------------------------------------
// Checksum step
// Combinational update of the accumulator for one item, plus the final fold.
// ---------------------------------------------------------------------------
module ocpc_step (
    input  ocpc_pkg::t_in_item i_item,
    input  logic [63:0]        i_acc,
    input  logic               i_odd,
    output ocpc_pkg::t_step    o_step
);

    logic [63:0] w_base;
    logic [63:0] w_acc;
    logic        w_odd;
    logic [31:0] w_f32;
    logic [15:0] w_f16;
    logic        w_odd_empty;

    assign w_odd_empty = i_item.first_item && i_item.odd_start
                         && (i_item.valid_bytes == 4'd0);

    always_comb begin
        w_base = i_item.first_item ? i_item.initial_sum : i_acc;
        if (i_item.first_item && i_item.odd_start) begin
            if (w_odd_empty) begin
                w_acc = i_item.initial_sum;
                w_odd = 1'b0;
            end else begin
                // lone leading byte goes into the high half of the first pair
                w_acc = {32'd0, i_item.initial_sum[7:0], i_item.initial_sum[31:8]}
                        + {48'd0, i_item.data_word[7:0], 8'd0};
                w_odd = 1'b1;
            end
        end else begin
            w_acc = ocpc_pkg::add_eac64(w_base,
                        ocpc_pkg::keep_bytes(i_item.data_word, i_item.valid_bytes));
            w_odd = i_item.first_item ? 1'b0 : i_odd;
        end
    end

    assign w_f32 = ocpc_pkg::fold_to32(w_acc);
    assign w_f16 = ocpc_pkg::fold_to16(w_f32);

    always_comb begin
        o_step.acc  = w_acc;
        o_step.odd  = w_odd;
        o_step.emit = i_item.last_item;
        if (w_odd_empty) begin
            o_step.checksum = i_item.initial_sum;
        end else if (w_odd) begin
            o_step.checksum = {48'd0, w_f16[7:0], w_f16[15:8]};
        end else begin
            o_step.checksum = {32'd0, w_f32};
        end
    end

endmodule

/* rtl/core/ones_complement_partial_checksum.sv */
// ---------------------------------------------------------------------------
// Ones-complement partial checksum
// Internet-style checksum accumulation over 64-bit little-endian words.
// ---------------------------------------------------------------------------
// Takes one 64-bit word per cycle when not stalled and, on the word flagged
// last, returns the folded checksum. An accepted transaction is registered in
// the input register, run through one end-around-carry add and the fold
// logic, and the result lands in the output register. The sustained rate is
// one item per clock when the block does not stall, set by the accumulator
// update loop. The input stays ready while a finished result waits for the
// sink; only when the result register is full, not taken, and the item in
// the input register is a last item does the block stall (ready then follows
// o_out.ready combinationally). Items carrying first_item load initial_sum;
// the accumulator keeps its value between messages.
// ---------------------------------------------------------------------------
`include "ones_complement_partial_checksum_macros.svh"

module ones_complement_partial_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ocpc_chan_if.sink   i_in,
    ocpc_chan_if.source o_out
);

    // input register
    logic               r_in_valid;
    logic               n_in_valid;
    ocpc_pkg::t_in_item r_in_item;

    // running state
    logic [63:0]        r_acc;
    logic               r_odd;

    // result register
    logic               r_out_valid;
    logic               n_out_valid;
    logic [63:0]        r_out_checksum;

    ocpc_pkg::t_step    w_step;
    logic               w_adv;   // item in the input register completes
    logic               w_in_ready;

    ocpc_step u_step (
        .i_item (r_in_item),
        .i_acc  (r_acc),
        .i_odd  (r_odd),
        .o_step (w_step)
    );

    // An item with no result always completes; one with a result needs room.
    assign w_adv      = r_in_valid && (!w_step.emit || !r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_in.ready = w_in_ready;

    always_comb begin
        n_in_valid = w_in_ready ? i_in.valid : r_in_valid;
        if (w_adv && w_step.emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= 64'd0;
            r_odd       <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_acc <= w_step.acc;
                r_odd <= w_step.odd;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
        if (w_adv && w_step.emit) begin
            r_out_checksum <= w_step.checksum;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.payload.checksum = r_out_checksum;

    // ---- checks ----
    // a fresh result only follows a completed last item
    `OCPC_ASSERT(a_result_from_last, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(w_adv && r_in_item.last_item), "result without last item")
    // odd-start results are a 16-bit swapped fold
    `OCPC_ASSERT(a_odd_narrow, i_clk, i_rst_n,
        (w_adv && w_step.emit && w_step.odd) |=> (r_out_checksum[63:16] == 48'd0),
        "odd-start checksum wider than 16 bits")
    // a completed non-last item leaves the output register alone
    `OCPC_ASSERT(a_no_spurious, i_clk, i_rst_n,
        (w_adv && !w_step.emit) |=> (r_out_valid == ($past(r_out_valid) && !$past(o_out.ready))),
        "output changed by non-last item")
    // never stall with an empty input register
    `OCPC_NEVER(a_ready_when_empty, i_clk, i_rst_n,
        !r_in_valid && !i_in.ready, "input stalled while empty")

endmodule
